@@ hdl/sapn_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sapn_pkg
// Shared widths, constants, payload types and the arctangent table for the
// signed angle about plane normal block.
// ----------------------------------------------------------------------------
package sapn_pkg;

    localparam int COMPONENT_BITS = 12;
    localparam int CORDIC_STAGES  = 16;
    localparam int ANGLE_BITS     = 16;

    localparam int CB         = COMPONENT_BITS;
    localparam int NSH        = (2 * CB > 24) ? (2 * CB - 24) : 0;
    localparam int PRODUCT_W  = 2 * CB;
    localparam int CROSS_W    = 2 * CB + 1;
    localparam int DOT_W      = 2 * CB + 1;
    localparam int NORM_W     = CROSS_W - NSH;
    localparam int DPROD_W    = CROSS_W + NORM_W;
    localparam int DET_W      = DPROD_W + 2;
    localparam int LEN2_W     = 2 * NORM_W;
    localparam int SQRT_W     = NORM_W;
    localparam int TW         = LEN2_W + 2;
    localparam int X_W        = DOT_W + SQRT_W + 1;
    localparam int CW         = ((DET_W > X_W) ? DET_W : X_W) + 3;
    localparam int Z_W        = 34;
    localparam int CORDIC_N   = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
    localparam int OUT_SHIFT  = 33 - ANGLE_BITS;

    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint PI_OUT      = (Q30_PI + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;

    localparam logic signed [Z_W-1:0]        HALF_PI_Z = Z_W'(Q30_HALF_PI);
    localparam logic signed [Z_W-1:0]        PI_Z      = Z_W'(PI_OUT);
    localparam logic signed [ANGLE_BITS-1:0] PI_ANGLE  = ANGLE_BITS'(PI_OUT);

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_FIRST_X  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_FIRST_Y  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_FIRST_Z  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_SECOND_X = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_SECOND_Y = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_SECOND_Z = 3'd5;

    typedef struct packed {
        logic signed [CB-1:0] fx;
        logic signed [CB-1:0] fy;
        logic signed [CB-1:0] fz;
        logic signed [CB-1:0] tx;
        logic signed [CB-1:0] ty;
        logic signed [CB-1:0] tz;
    } vec_t;

    typedef struct packed {
        logic signed [CB-1:0] ax;
        logic signed [CB-1:0] ay;
        logic signed [CB-1:0] az;
        logic signed [CB-1:0] bx;
        logic signed [CB-1:0] by;
        logic signed [CB-1:0] bz;
    } plane_t;

    typedef struct packed {
        logic signed [DET_W-1:0] det;
        logic signed [DOT_W-1:0] dot;
        logic                    degen;
    } side_t;

    function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [Z_W-1:0] a;
        case (i)
            5'd0:    a = 34'sd843314857;
            5'd1:    a = 34'sd497837829;
            5'd2:    a = 34'sd263043837;
            5'd3:    a = 34'sd133525159;
            5'd4:    a = 34'sd67021687;
            5'd5:    a = 34'sd33543516;
            5'd6:    a = 34'sd16775851;
            5'd7:    a = 34'sd8388437;
            5'd8:    a = 34'sd4194283;
            5'd9:    a = 34'sd2097149;
            5'd10:   a = 34'sd1048576;
            5'd11:   a = 34'sd524288;
            5'd12:   a = 34'sd262144;
            5'd13:   a = 34'sd131072;
            5'd14:   a = 34'sd65536;
            5'd15:   a = 34'sd32768;
            5'd16:   a = 34'sd16384;
            5'd17:   a = 34'sd8192;
            5'd18:   a = 34'sd4096;
            5'd19:   a = 34'sd2048;
            5'd20:   a = 34'sd1024;
            5'd21:   a = 34'sd512;
            5'd22:   a = 34'sd256;
            5'd23:   a = 34'sd128;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

@@ hdl/sapn_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sapn_item_if / sapn_result_if / sapn_cfg_if
// Valid/ready channels for vector pairs, angle results and register writes.
// ----------------------------------------------------------------------------
interface sapn_item_if import sapn_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [CB-1:0] from_x;
    logic signed [CB-1:0] from_y;
    logic signed [CB-1:0] from_z;
    logic signed [CB-1:0] to_x;
    logic signed [CB-1:0] to_y;
    logic signed [CB-1:0] to_z;
    modport source (output valid, from_x, from_y, from_z, to_x, to_y, to_z, input ready);
    modport sink   (input valid, from_x, from_y, from_z, to_x, to_y, to_z, output ready);
endinterface

interface sapn_result_if import sapn_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] angle;
    logic                         degenerate_plane;
    modport source (output valid, angle, degenerate_plane, input ready);
    modport sink   (input valid, angle, degenerate_plane, output ready);
endinterface

interface sapn_cfg_if import sapn_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CB-1:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/sapn_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sapn_front
// Products, cross/dot sums, triple product and squared normal length.
// ----------------------------------------------------------------------------
module sapn_front import sapn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire vec_t              vec,
    input  wire plane_t            plane,
    output logic                   out_valid,
    output side_t                  out_side,
    output logic [LEN2_W-1:0]      out_len2
);

    logic                        a_v_reg, b_v_reg, c_v_reg, d_v_reg;
    logic signed [PRODUCT_W-1:0] xp_reg [9];
    logic signed [PRODUCT_W-1:0] np_reg [6];
    logic signed [CROSS_W-1:0]   c_reg [3];
    logic signed [NORM_W-1:0]    n_reg [3];
    logic signed [DOT_W-1:0]     b_dot_reg, c_dot_reg;
    logic                        b_degen_reg, c_degen_reg;
    logic signed [DPROD_W-1:0]   dp_reg [3];
    logic signed [LEN2_W-1:0]    sq_reg [3];
    side_t                       d_side_reg;
    logic [LEN2_W-1:0]           d_len2_reg;
    logic signed [CROSS_W-1:0]   nr [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nr[i] = CROSS_W'(np_reg[2 * i]) - CROSS_W'(np_reg[2 * i + 1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xp_reg[0] <= vec.fy * vec.tz;
            xp_reg[1] <= vec.fz * vec.ty;
            xp_reg[2] <= vec.fz * vec.tx;
            xp_reg[3] <= vec.fx * vec.tz;
            xp_reg[4] <= vec.fx * vec.ty;
            xp_reg[5] <= vec.fy * vec.tx;
            xp_reg[6] <= vec.fx * vec.tx;
            xp_reg[7] <= vec.fy * vec.ty;
            xp_reg[8] <= vec.fz * vec.tz;
            np_reg[0] <= plane.ay * plane.bz;
            np_reg[1] <= plane.az * plane.by;
            np_reg[2] <= plane.az * plane.bx;
            np_reg[3] <= plane.ax * plane.bz;
            np_reg[4] <= plane.ax * plane.by;
            np_reg[5] <= plane.ay * plane.bx;

            for (int i = 0; i < 3; i++)
            begin
                c_reg[i] <= CROSS_W'(xp_reg[2 * i]) - CROSS_W'(xp_reg[2 * i + 1]);
                n_reg[i] <= NORM_W'(nr[i] >>> NSH);
            end
            b_dot_reg   <= DOT_W'(xp_reg[6]) + DOT_W'(xp_reg[7]) + DOT_W'(xp_reg[8]);
            b_degen_reg <= (nr[0] == '0) && (nr[1] == '0) && (nr[2] == '0);

            for (int i = 0; i < 3; i++)
            begin
                dp_reg[i] <= c_reg[i] * n_reg[i];
                sq_reg[i] <= n_reg[i] * n_reg[i];
            end
            c_dot_reg   <= b_dot_reg;
            c_degen_reg <= b_degen_reg;

            d_side_reg.det   <= DET_W'(dp_reg[0]) + DET_W'(dp_reg[1]) + DET_W'(dp_reg[2]);
            d_side_reg.dot   <= c_dot_reg;
            d_side_reg.degen <= c_degen_reg;
            d_len2_reg       <= $unsigned(sq_reg[0]) + $unsigned(sq_reg[1])
                              + $unsigned(sq_reg[2]);
        end
    end

    assign out_valid = d_v_reg;
    assign out_side  = d_side_reg;
    assign out_len2  = d_len2_reg;

endmodule
`default_nettype wire

@@ hdl/sapn_isqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sapn_isqrt
// Pipelined floor square root, one result bit per stage, sideband carried.
// ----------------------------------------------------------------------------
module sapn_isqrt import sapn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire side_t             in_side,
    input  wire logic [LEN2_W-1:0] in_len2,
    output logic                   out_valid,
    output side_t                  out_side,
    output logic [SQRT_W-1:0]      out_len
);

    logic              v_reg    [SQRT_W];
    side_t             side_reg [SQRT_W];
    logic [TW-1:0]     rem_reg  [SQRT_W];
    logic [SQRT_W-1:0] root_reg [SQRT_W];

    for (genvar k = 0; k < SQRT_W; k++)
    begin : g_stage
        localparam int B = SQRT_W - 1 - k;
        logic              v_in;
        side_t             side_in;
        logic [TW-1:0]     rem_in;
        logic [SQRT_W-1:0] root_in;
        logic [TW-1:0]     trial;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign rem_in  = TW'(in_len2);
            assign root_in = '0;
        end
        else
        begin : g_next
            assign v_in    = v_reg[k - 1];
            assign side_in = side_reg[k - 1];
            assign rem_in  = rem_reg[k - 1];
            assign root_in = root_reg[k - 1];
        end

        assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_in;
                if (trial <= rem_in)
                begin
                    rem_reg[k]  <= rem_in - trial;
                    root_reg[k] <= root_in | (SQRT_W'(1) << B);
                end
                else
                begin
                    rem_reg[k]  <= rem_in;
                    root_reg[k] <= root_in;
                end
            end
        end
    end

    assign out_valid = v_reg[SQRT_W - 1];
    assign out_side  = side_reg[SQRT_W - 1];
    assign out_len   = root_reg[SQRT_W - 1];

endmodule
`default_nettype wire

@@ hdl/sapn_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sapn_cordic
// Cosine scaling, quadrant fold, vectoring CORDIC stages, round and clamp.
// ----------------------------------------------------------------------------
module sapn_cordic import sapn_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire side_t               in_side,
    input  wire logic [SQRT_W-1:0]   in_len,
    output logic                     out_valid,
    output logic signed [ANGLE_BITS-1:0] out_angle,
    output logic                     out_degen
);

    logic                    m_v_reg, p_v_reg, r_v_reg;
    logic signed [X_W-1:0]   m_x_reg;
    logic signed [DET_W-1:0] m_y_reg;
    logic                    m_degen_reg;
    logic signed [CW-1:0]    p_x_reg, p_y_reg;
    logic signed [Z_W-1:0]   p_z_reg;
    logic                    p_kill_reg, p_degen_reg;
    logic signed [CW-1:0]    p_x_next, p_y_next;
    logic signed [Z_W-1:0]   p_z_next;

    logic                    v_reg     [CORDIC_N];
    logic signed [CW-1:0]    x_reg     [CORDIC_N];
    logic signed [CW-1:0]    y_reg     [CORDIC_N];
    logic signed [Z_W-1:0]   z_reg     [CORDIC_N];
    logic                    kill_reg  [CORDIC_N];
    logic                    degen_reg [CORDIC_N];

    logic signed [ANGLE_BITS-1:0] r_angle_reg;
    logic                         r_degen_reg;
    logic signed [Z_W-1:0]        zr;

    always_comb
    begin
        p_x_next = CW'(m_x_reg);
        p_y_next = CW'(m_y_reg);
        p_z_next = '0;
        if (m_x_reg < 0)
        begin
            if (m_y_reg >= 0)
            begin
                p_x_next = CW'(m_y_reg);
                p_y_next = -CW'(m_x_reg);
                p_z_next = HALF_PI_Z;
            end
            else
            begin
                p_x_next = -CW'(m_y_reg);
                p_y_next = CW'(m_x_reg);
                p_z_next = -HALF_PI_Z;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg <= 1'b0;
            p_v_reg <= 1'b0;
        end
        else if (en)
        begin
            m_v_reg <= in_valid;
            p_v_reg <= m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_x_reg     <= in_side.dot * $signed({1'b0, in_len});
            m_y_reg     <= in_side.det;
            m_degen_reg <= in_side.degen;
            p_x_reg     <= p_x_next;
            p_y_reg     <= p_y_next;
            p_z_reg     <= p_z_next;
            p_kill_reg  <= m_degen_reg || ((m_x_reg == '0) && (m_y_reg == '0));
            p_degen_reg <= m_degen_reg;
        end
    end

    for (genvar i = 0; i < CORDIC_N; i++)
    begin : g_stage
        logic                  v_in, kill_in, degen_in;
        logic signed [CW-1:0]  x_in, y_in, xs, ys;
        logic signed [Z_W-1:0] z_in;

        if (i == 0)
        begin : g_first
            assign v_in     = p_v_reg;
            assign x_in     = p_x_reg;
            assign y_in     = p_y_reg;
            assign z_in     = p_z_reg;
            assign kill_in  = p_kill_reg;
            assign degen_in = p_degen_reg;
        end
        else
        begin : g_next
            assign v_in     = v_reg[i - 1];
            assign x_in     = x_reg[i - 1];
            assign y_in     = y_reg[i - 1];
            assign z_in     = z_reg[i - 1];
            assign kill_in  = kill_reg[i - 1];
            assign degen_in = degen_reg[i - 1];
        end

        assign xs = x_in >>> i;
        assign ys = y_in >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                kill_reg[i]  <= kill_in;
                degen_reg[i] <= degen_in;
                if (y_in >= 0)
                begin
                    x_reg[i] <= x_in + ys;
                    y_reg[i] <= y_in - xs;
                    z_reg[i] <= z_in + atan_q30(5'(i));
                end
                else
                begin
                    x_reg[i] <= x_in - ys;
                    y_reg[i] <= y_in + xs;
                    z_reg[i] <= z_in - atan_q30(5'(i));
                end
            end
        end
    end

    assign zr = (z_reg[CORDIC_N - 1] + (Z_W'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_v_reg <= 1'b0;
        end
        else if (en)
        begin
            r_v_reg <= v_reg[CORDIC_N - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_degen_reg <= degen_reg[CORDIC_N - 1];
            if (kill_reg[CORDIC_N - 1])
            begin
                r_angle_reg <= '0;
            end
            else if (zr > PI_Z)
            begin
                r_angle_reg <= PI_ANGLE;
            end
            else if (zr < -PI_Z)
            begin
                r_angle_reg <= -PI_ANGLE;
            end
            else
            begin
                r_angle_reg <= ANGLE_BITS'(zr);
            end
        end
    end

    assign out_valid = r_v_reg;
    assign out_angle = r_angle_reg;
    assign out_degen = r_degen_reg;

endmodule
`default_nettype wire

@@ hdl/signed_angle_about_plane_normal.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// signed_angle_about_plane_normal
// Signed angle from one vector to another about a configured plane normal.
// ----------------------------------------------------------------------------
// Takes one vector pair per cycle while the output is not stalled and returns
// one Q3.13 angle per pair, in order, through four product/sum stages, one
// square root stage per result bit of the normal length, cosine scaling and
// quadrant fold, one stage per CORDIC iteration and a round/clamp stage. The
// whole pipeline, empty slots included, freezes while a finished angle waits
// in the output stage and the sink is not ready. Plane registers are written
// through the cfg channel, which is always ready; write them only while no
// pair is in flight. A zero normal gives angle 0 with degenerate_plane set.
// ----------------------------------------------------------------------------
module signed_angle_about_plane_normal import sapn_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    sapn_cfg_if.sink     cfg,
    sapn_item_if.sink    vectors,
    sapn_result_if.source result
);

    plane_t          plane_reg;
    vec_t            vec;
    logic            en;
    logic            f_valid, s_valid;
    side_t           f_side, s_side;
    logic [LEN2_W-1:0] f_len2;
    logic [SQRT_W-1:0] s_len;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PLANE_FIRST_X:  plane_reg.ax <= cfg.data;
                REG_PLANE_FIRST_Y:  plane_reg.ay <= cfg.data;
                REG_PLANE_FIRST_Z:  plane_reg.az <= cfg.data;
                REG_PLANE_SECOND_X: plane_reg.bx <= cfg.data;
                REG_PLANE_SECOND_Y: plane_reg.by <= cfg.data;
                REG_PLANE_SECOND_Z: plane_reg.bz <= cfg.data;
                default: ;
            endcase
        end
    end

    assign en            = !result.valid || result.ready;
    assign vectors.ready = en;

    assign vec.fx = vectors.from_x;
    assign vec.fy = vectors.from_y;
    assign vec.fz = vectors.from_z;
    assign vec.tx = vectors.to_x;
    assign vec.ty = vectors.to_y;
    assign vec.tz = vectors.to_z;

    sapn_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vectors.valid),
        .vec       (vec),
        .plane     (plane_reg),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_len2  (f_len2)
    );

    sapn_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_len2   (f_len2),
        .out_valid (s_valid),
        .out_side  (s_side),
        .out_len   (s_len)
    );

    sapn_cordic u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .in_side   (s_side),
        .in_len    (s_len),
        .out_valid (result.valid),
        .out_angle (result.angle),
        .out_degen (result.degenerate_plane)
    );

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.degenerate_plane |-> result.angle == '0)
        else $error("degenerate plane with nonzero angle");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ($signed(result.angle) <= PI_ANGLE)
                      && ($signed(result.angle) >= -PI_ANGLE))
        else $error("angle outside plus or minus pi");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !result.valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !vectors.ready)
        else $error("input taken while output beat stalled");
`endif

endmodule
`default_nettype wire

@@ bench/signed_angle_about_plane_normal_tb.sv @@
// ----------------------------------------------------------------------------
// signed_angle_about_plane_normal_tb
// Self-checking bench: drives vector pairs under a series of plane settings,
// predicts each signed angle in a local fixed-point CORDIC model and compares
// every result beat in order, with random pair gaps and result-side stalls.
// ----------------------------------------------------------------------------
module signed_angle_about_plane_normal_tb import sapn_pkg::*;;

    localparam int HALF_PERIOD = 6;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] angle;
        logic                         degen;
    } angle_result_t;

    localparam longint ARCTAN_Q30 [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    logic clk;
    logic rst_n;

    sapn_cfg_if    cfg_if ();
    sapn_item_if   vec_if ();
    sapn_result_if res_if ();

    signed_angle_about_plane_normal dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_if),
        .vectors (vec_if),
        .result  (res_if)
    );

    vec_t          pending_pairs [$];
    angle_result_t expected_angles [$];
    plane_t        plane_shadow;
    int            mismatches;
    int            cycle_count;
    int            send_gap;
    int            sink_stall;
    logic          send_burst;
    logic          sink_burst;
    logic          pair_beat;
    logic          angle_beat;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #HALF_PERIOD clk = ~clk;
        end
    end

    function automatic angle_result_t predict_angle(vec_t v, plane_t p);
        angle_result_t res;
        longint ax, ay, az, bx, by, bz, fx, fy, fz, tx, ty, tz;
        longint nx, ny, nz, dot, det, cx, cy, cz, x, y, z, xs, ys, t, r;
        longint unsigned rem, root, bitv;
        ax = p.ax; ay = p.ay; az = p.az;
        bx = p.bx; by = p.by; bz = p.bz;
        fx = v.fx; fy = v.fy; fz = v.fz;
        tx = v.tx; ty = v.ty; tz = v.tz;
        nx = ay * bz - az * by;
        ny = az * bx - ax * bz;
        nz = ax * by - ay * bx;
        res.angle = '0;
        res.degen = 1'b0;
        if (nx == 0 && ny == 0 && nz == 0)
        begin
            res.degen = 1'b1;
            return res;
        end
        nx = nx >>> NSH;
        ny = ny >>> NSH;
        nz = nz >>> NSH;
        dot = fx * tx + fy * ty + fz * tz;
        cx = fy * tz - fz * ty;
        cy = fz * tx - fx * tz;
        cz = fx * ty - fy * tx;
        det = cx * nx + cy * ny + cz * nz;
        rem = longint'(nx * nx) + longint'(ny * ny) + longint'(nz * nz);
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        x = dot * longint'(root);
        y = det;
        z = 0;
        if (!(x == 0 && y == 0))
        begin
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y; y = -t; z = Q30_HALF_PI;
                end
                else
                begin
                    x = -y; y = t; z = -Q30_HALF_PI;
                end
            end
            for (int i = 0; i < CORDIC_N; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys; y = y - xs; z = z + ARCTAN_Q30[i];
                end
                else
                begin
                    x = x - ys; y = y + xs; z = z - ARCTAN_Q30[i];
                end
            end
        end
        r = (z + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        if (r > PI_OUT)
            r = PI_OUT;
        if (r < -PI_OUT)
            r = -PI_OUT;
        res.angle = ANGLE_BITS'(r);
        return res;
    endfunction

    function automatic int draw_wait(logic burst);
        if (burst)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    function automatic logic [CB-1:0] draw_component(int mode);
        case (mode)
            0:       return CB'($urandom_range(0, 8)) - CB'(4);
            1:       return ($urandom_range(0, 1) != 0) ? {1'b0, {(CB-1){1'b1}}}
                                                        : {1'b1, {(CB-1){1'b0}}};
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic vec_t draw_pair();
        vec_t v;
        int mode;
        mode = $urandom_range(0, 9);
        mode = (mode == 0) ? 0 : (mode == 1) ? 1 : 2;
        v.fx = draw_component(mode);
        v.fy = draw_component(mode);
        v.fz = draw_component(mode);
        v.tx = draw_component(mode);
        v.ty = draw_component(mode);
        v.tz = draw_component(mode);
        if ($urandom_range(0, 15) == 0)
        begin
            v.tx = -v.fx; v.ty = -v.fy; v.tz = -v.fz;
        end
        return v;
    endfunction

    task automatic report_mismatch(string what, angle_result_t want, angle_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): expected angle %0d degen %0b, got angle %0d degen %0b",
                     what, want.angle, want.degen, got.angle, got.degen);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CB-1:0] data);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (index)
            REG_PLANE_FIRST_X:  plane_shadow.ax = data;
            REG_PLANE_FIRST_Y:  plane_shadow.ay = data;
            REG_PLANE_FIRST_Z:  plane_shadow.az = data;
            REG_PLANE_SECOND_X: plane_shadow.bx = data;
            REG_PLANE_SECOND_Y: plane_shadow.by = data;
            REG_PLANE_SECOND_Z: plane_shadow.bz = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_plane(plane_t p);
        write_reg(REG_PLANE_FIRST_X, p.ax);
        write_reg(REG_PLANE_FIRST_Y, p.ay);
        write_reg(REG_PLANE_FIRST_Z, p.az);
        write_reg(REG_PLANE_SECOND_X, p.bx);
        write_reg(REG_PLANE_SECOND_Y, p.by);
        write_reg(REG_PLANE_SECOND_Z, p.bz);
    endtask

    task automatic wait_idle();
        wait (pending_pairs.size() == 0 && !vec_if.valid && expected_angles.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            pending_pairs.push_back(draw_pair());
    endtask

    // pair beats and result beats
    always @(posedge clk)
    begin
        angle_result_t got;
        angle_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        pair_beat  <= vec_if.valid && vec_if.ready;
        angle_beat <= res_if.valid && res_if.ready;
        if (rst_n && vec_if.valid && vec_if.ready)
            expected_angles.push_back(predict_angle('{fx: vec_if.from_x, fy: vec_if.from_y,
                fz: vec_if.from_z, tx: vec_if.to_x, ty: vec_if.to_y, tz: vec_if.to_z},
                plane_shadow));
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.angle = res_if.angle;
            got.degen = res_if.degenerate_plane;
            if (expected_angles.size() == 0)
                report_mismatch("unexpected beat", '0, got);
            else
            begin
                want = expected_angles.pop_front();
                if (got.angle !== want.angle)
                    report_mismatch("angle", want, got);
                else if (got.degen !== want.degen)
                    report_mismatch("degenerate_plane", want, got);
            end
        end
    end

    // pair driver
    always @(negedge clk)
    begin
        vec_t nxt;
        logic nv;
        if (rst_n)
        begin
            nv = vec_if.valid;
            if (nv && pair_beat)
                nv = 1'b0;
            if ($urandom_range(0, 39) == 0)
                send_burst = ~send_burst;
            if (!nv)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_pairs.size() > 0)
                begin
                    nxt = pending_pairs.pop_front();
                    vec_if.from_x <= nxt.fx;
                    vec_if.from_y <= nxt.fy;
                    vec_if.from_z <= nxt.fz;
                    vec_if.to_x   <= nxt.tx;
                    vec_if.to_y   <= nxt.ty;
                    vec_if.to_z   <= nxt.tz;
                    nv = 1'b1;
                    send_gap = draw_wait(send_burst);
                end
            end
            vec_if.valid <= nv;
        end
    end

    // result sink stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 39) == 0)
                sink_burst = ~sink_burst;
            if (angle_beat)
                sink_stall = draw_wait(sink_burst);
            if (sink_stall > 0)
            begin
                sink_stall--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    initial
    begin
        plane_t p;
        vec_t v;
        rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        vec_if.valid = 1'b0;
        vec_if.from_x = '0; vec_if.from_y = '0; vec_if.from_z = '0;
        vec_if.to_x = '0; vec_if.to_y = '0; vec_if.to_z = '0;
        res_if.ready = 1'b0;
        plane_shadow = '0;
        mismatches = 0;
        cycle_count = 0;
        send_gap = 0;
        sink_stall = 0;
        send_burst = 1'b0;
        sink_burst = 1'b0;
        pair_beat = 1'b0;
        angle_beat = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset plane is all zero: every pair is degenerate
        queue_random(20);
        wait_idle();

        // xy plane, normal along +z
        p = '0;
        p.ax = 12'sd2047;
        p.by = 12'sd2047;
        set_plane(p);
        v = '0; pending_pairs.push_back(v);
        v = '0; v.fx = 1; v.tx = -1; pending_pairs.push_back(v);
        v = '0; v.fx = 1; v.ty = 1; pending_pairs.push_back(v);
        v = '0; v.fy = 1; v.tx = 1; pending_pairs.push_back(v);
        v = '0; v.fx = 1; v.tx = 1; pending_pairs.push_back(v);
        v = '0; v.fx = 5; v.tx = -3; v.ty = -1; pending_pairs.push_back(v);
        v = '0; v.fx = 5; v.tx = -3; v.ty = 1; pending_pairs.push_back(v);
        v = '0; v.fx = -2048; v.fy = -2048; v.fz = -2048;
        v.tx = -2048; v.ty = -2048; v.tz = -2048; pending_pairs.push_back(v);
        v = '0; v.fx = 2047; v.fy = 2047; v.fz = 2047;
        v.tx = 2047; v.ty = 2047; v.tz = 2047; pending_pairs.push_back(v);
        v = '0; v.fx = -2048; v.fy = 2047; v.tx = 2047; v.ty = -2048; v.tz = -2048;
        pending_pairs.push_back(v);
        v = '0; v.fx = 2047; v.ty = -2048; v.fz = -2048; v.tz = 2047;
        pending_pairs.push_back(v);
        v = '0; v.fz = 7; v.tz = -7; pending_pairs.push_back(v);
        v = '0; v.fx = 3; v.fy = 4; pending_pairs.push_back(v);
        wait_idle();

        // out of range indexes are ignored
        write_reg(CFG_INDEX_W'(6), CB'($urandom));
        write_reg(CFG_INDEX_W'(7), CB'($urandom));
        queue_random(10);
        wait_idle();

        // extreme plane corners
        p.ax = -12'sd2048; p.ay = 12'sd2047; p.az = -12'sd2048;
        p.bx = 12'sd2047; p.by = -12'sd2048; p.bz = 12'sd2047;
        set_plane(p);
        queue_random(90);
        wait_idle();

        p.ax = -12'sd2048; p.ay = -12'sd2048; p.az = -12'sd2048;
        p.bx = 12'sd2047; p.by = 12'sd2047; p.bz = -12'sd2048;
        set_plane(p);
        queue_random(90);
        wait_idle();

        // parallel plane vectors
        p.ax = 12'sd3; p.ay = -12'sd5; p.az = 12'sd7;
        p.bx = -12'sd6; p.by = 12'sd10; p.bz = -12'sd14;
        set_plane(p);
        queue_random(40);
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph % 2 == 0)
            begin
                p.ax = CB'($urandom); p.ay = CB'($urandom); p.az = CB'($urandom);
                p.bx = CB'($urandom); p.by = CB'($urandom); p.bz = CB'($urandom);
            end
            else
            begin
                p.ax = CB'($urandom_range(0, 6)) - CB'(3);
                p.ay = CB'($urandom_range(0, 6)) - CB'(3);
                p.az = CB'($urandom_range(0, 6)) - CB'(3);
                p.bx = CB'($urandom_range(0, 6)) - CB'(3);
                p.by = CB'($urandom_range(0, 6)) - CB'(3);
                p.bz = CB'($urandom_range(0, 6)) - CB'(3);
            end
            set_plane(p);
            queue_random(85);
            wait_idle();
        end

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
hdl/sapn_pkg.sv
hdl/sapn_if.sv
hdl/sapn_front.sv
hdl/sapn_isqrt.sv
hdl/sapn_cordic.sv
hdl/signed_angle_about_plane_normal.sv
bench/signed_angle_about_plane_normal_tb.sv
